@@ src/escdec_pkg.sv @@
// Shared types and character codes for the escape sequence decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package escdec_pkg;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Decoded values of the single-letter escapes
    localparam logic [7:0] VAL_BSLASH = 8'd92;
    localparam logic [7:0] VAL_BEL    = 8'd7;
    localparam logic [7:0] VAL_BS     = 8'd8;
    localparam logic [7:0] VAL_ESC    = 8'h1b;
    localparam logic [7:0] VAL_FF     = 8'd12;
    localparam logic [7:0] VAL_LF     = 8'd10;
    localparam logic [7:0] VAL_CR     = 8'd13;
    localparam logic [7:0] VAL_TAB    = 8'd9;
    localparam logic [7:0] VAL_VT     = 8'd11;

    // Offsets that turn letters into hex digit values (10 + c - 'a', 10 + c - 'A')
    localparam logic [7:0] LC_HEX_OFS = 8'd87;
    localparam logic [7:0] UC_HEX_OFS = 8'd55;

    // One accepted input word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_word_t;

    // One decoded result word
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic       err;
    } res_word_t;

endpackage

@@ src/escape_sequence_decoder.sv @@
// Top level of the escape sequence decoder: input stage, decode step, result register.
// Depends on escdec_pkg, escdec_in_stage and escdec_step.
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel s_*: one raw string byte per word in s_tdata, s_tlast on the
//   final byte of the string. Master channel m_*: m_tdata is the decoded byte
//   (zero when m_tuser[0] is low), m_tuser[0] says it carries a character,
//   m_tlast marks the result of the string's last byte and m_tuser[1] then
//   flags a bad or unfinished escape. Bytes that only advance an escape
//   produce no output word; the last byte always produces one.
//   Path: input register, then decode into the result register, which drives
//   the master side.
//   Throughput: one byte per cycle while the result slot is free, set by the single
//   phase/accumulator update that each byte makes in the decode step.
//   When the receiver stalls, the result register holds its word and the input
//   register holds one more; s_tready drops only once both are occupied.
//   Reset clears the valid flags, the escape phase and the accumulator; the
//   block is ready for a new string once reset is released.
//

module escape_sequence_decoder
    import escdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // done_res
    output logic [1:0] m_tuser    // [0] out_valid, [1] error
);

    in_word_t  in_word;
    logic      in_full;
    logic      advance;
    logic      out_free;
    logic      emit;
    res_word_t res;
    logic      m_valid_reg;
    logic      m_valid_next;
    res_word_t m_word_reg;

    // Move the held input word through decode when the result slot is free
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_full && out_free;

    escdec_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .full     (in_full),
        .word     (in_word)
    );

    escdec_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .word    (in_word),
        .emit    (emit),
        .res     (res)
    );

    // Result register valid: load on a decode step, drop once taken
    always_comb
    begin
        if (advance)
        begin
            m_valid_next = emit;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            m_word_reg <= res;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_word_reg.data;
    assign m_tlast    = m_word_reg.done;
    assign m_tuser[0] = m_word_reg.valid;
    assign m_tuser[1] = m_word_reg.err;

    a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("error flag without done");

    a_word_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] || m_tlast)
        else $error("result word with neither data nor done");

endmodule

@@ src/escdec_in_stage.sv @@
// Input register of the escape sequence decoder: holds one accepted word.
// Depends on escdec_pkg.
`timescale 1ns / 1ps

module escdec_in_stage
    import escdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    input  logic       advance,
    output logic       full,
    output in_word_t   word
);

    logic     vld_reg;
    logic     vld_next;
    in_word_t word_reg;

    // Take a new word when empty or whenever the held one moves on this cycle
    assign s_tready = !vld_reg || advance;
    assign vld_next = (s_tvalid && s_tready) || (vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture payload on acceptance
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg.data <= s_tdata;
            word_reg.last <= s_tlast;
        end
    end

    assign full = vld_reg;
    assign word = word_reg;

endmodule

@@ src/escdec_step.sv @@
// Escape phase tracking and one-byte decode for the escape sequence decoder.
// Depends on escdec_pkg.
`timescale 1ns / 1ps

module escdec_step
    import escdec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_word_t  word,
    output logic      emit,
    output res_word_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_OCT2,
        PH_OCT3,
        PH_ERR
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     ph_dec;
    logic [7:0] accum_reg;
    logic [7:0] accum_next;
    logic [7:0] acc_dec;
    logic [7:0] hex_val;
    logic [7:0] dig_val;
    logic [7:0] val;
    logic       have;
    logic [7:0] c;

    assign c = word.data;

    // Digit values, unchecked: letters a..f / A..F map to 10..15, else c - '0'
    assign dig_val = c - CH_ZERO;

    always_comb
    begin
        if (c >= CH_LC_A && c <= CH_LC_F)
        begin
            hex_val = c - LC_HEX_OFS;
        end
        else if (c >= CH_UC_A && c <= CH_UC_F)
        begin
            hex_val = c - UC_HEX_OFS;
        end
        else
        begin
            hex_val = dig_val;
        end
    end

    // Decode one byte against the current phase
    always_comb
    begin
        have    = 1'b0;
        val     = 8'd0;
        ph_dec  = PH_IDLE;
        acc_dec = accum_reg;
        unique case (phase_reg)
            PH_ESC:
            begin
                have = 1'b1;
                unique case (c)
                    CH_BSLASH: val = VAL_BSLASH;
                    CH_LC_A:   val = VAL_BEL;
                    CH_LC_B:   val = VAL_BS;
                    CH_LC_E:   val = VAL_ESC;
                    CH_LC_F:   val = VAL_FF;
                    CH_LC_N:   val = VAL_LF;
                    CH_LC_R:   val = VAL_CR;
                    CH_LC_T:   val = VAL_TAB;
                    CH_LC_V:   val = VAL_VT;
                    CH_LC_X:
                    begin
                        have   = 1'b0;
                        ph_dec = PH_HEX1;
                    end
                    default:
                    begin
                        have = 1'b0;
                        if (c >= CH_ZERO && c <= CH_NINE)
                        begin
                            acc_dec = {dig_val[1:0], 6'd0};
                            ph_dec  = PH_OCT2;
                        end
                        else
                        begin
                            ph_dec = PH_ERR;
                        end
                    end
                endcase
            end
            PH_HEX1:
            begin
                acc_dec = {hex_val[3:0], 4'd0};
                ph_dec  = PH_HEX2;
            end
            PH_HEX2:
            begin
                val  = accum_reg + hex_val;
                have = 1'b1;
            end
            PH_OCT2:
            begin
                acc_dec = accum_reg + {dig_val[4:0], 3'd0};
                ph_dec  = PH_OCT3;
            end
            PH_OCT3:
            begin
                val  = accum_reg + dig_val;
                have = 1'b1;
            end
            PH_ERR:
            begin
                ph_dec = PH_ERR;
            end
            default:
            begin
                // idle and the unused code: pass plain bytes, open escape on backslash
                if (c == CH_BSLASH)
                begin
                    ph_dec = PH_ESC;
                end
                else
                begin
                    val  = c;
                    have = 1'b1;
                end
            end
        endcase
    end

    // Close the string on the last byte; clear the accumulator when idle
    always_comb
    begin
        if (word.last || ph_dec == PH_IDLE)
        begin
            phase_next = PH_IDLE;
            accum_next = 8'd0;
        end
        else
        begin
            phase_next = ph_dec;
            accum_next = acc_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            accum_reg <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
        end
    end

    // Result word for this byte
    assign emit      = have || word.last;
    assign res.data  = have ? val : 8'd0;
    assign res.valid = have;
    assign res.done  = word.last;
    assign res.err   = word.last && (ph_dec != PH_IDLE);

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && word.last |=> phase_reg == PH_IDLE)
        else $error("phase not idle after last byte");

    a_idle_accum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> accum_reg == 8'd0)
        else $error("accumulator not clear in idle phase");

    a_err_stays: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR && !(step_en && word.last) |=> phase_reg == PH_ERR)
        else $error("error phase left before end of string");

    a_hold_when_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(accum_reg))
        else $error("state moved without a decode step");

endmodule
